// ===== hw/rtl/mppt_spo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPPT sweep / P&O package
// Field widths, register map codes, reset values and payload structs shared
// by the tracker, its port checker and the testbench.
// ----------------------------------------------------------------------------
package mppt_spo_pkg;

    localparam int ADC_BITS  = 10;
    localparam int DUTY_BITS = 14;
    localparam int REG_W     = 14;
    localparam int POWER_W   = 20;
    localparam int PROD_W    = 2 * ADC_BITS;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};

    // Reset values of the configuration registers.
    localparam logic [POWER_W-1:0] RST_POWER_FLOOR = POWER_W'(2045);
    localparam logic [REG_W-1:0]   RST_SWEEP_START = REG_W'(5500);
    localparam logic [REG_W-1:0]   RST_SWEEP_STEP  = REG_W'(100);
    localparam logic [REG_W-1:0]   RST_SWEEP_END   = REG_W'(9500);
    localparam logic [REG_W-1:0]   RST_TRACK_STEP  = REG_W'(50);
    localparam logic [REG_W-1:0]   RST_DUTY_MIN    = REG_W'(5000);
    localparam logic [REG_W-1:0]   RST_DUTY_MAX    = REG_W'(8700);

    typedef enum logic [2:0] {
        REG_POWER_FLOOR = 3'd0,
        REG_SWEEP_START = 3'd1,
        REG_SWEEP_STEP  = 3'd2,
        REG_SWEEP_END   = 3'd3,
        REG_TRACK_STEP  = 3'd4,
        REG_DUTY_MIN    = 3'd5,
        REG_DUTY_MAX    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [ADC_BITS-1:0] voltage_code;
        logic [ADC_BITS-1:0] current_code;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty;
        logic                 tracking;
        logic [POWER_W-1:0]   power;
    } t_out_item;

endpackage

// ===== hw/rtl/mppt_sweep_then_perturb_observe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPPT tracker: startup sweep, then perturb and observe
// Takes one voltage/current ADC pair per transfer, forms the raw power and
// answers with the next duty, the phase and the power of that sample.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                payload
//  --------  ---------  -----------------------  ----------------------------
//  in        sink       i_in_valid / o_in_ready  i_in_data  (t_in_item)
//  out       source     o_out_valid / i_out_ready o_out_data (t_out_item)
//  config    APB slave  psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  Rates: one transfer per clock in each direction while out is not stalled;
//  a sample is caught in the input register at its transfer edge, and its
//  result is captured in the result register, from which it can transfer.
//  The whole per-sample step (10x10 multiply, compares, clamp) sits between
//  the input register and the result register.
//  Reset (i_rst_n low, synchronous): registers take their defaults, phase is
//  sweep, duty is the sweep start; both stages empty.
//  Stalls: while a result waits on the output, the input register accepts
//  only if empty; it holds only when both stages are full and out is stalled.
// ----------------------------------------------------------------------------
module mppt_sweep_then_perturb_observe (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input sample channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  mppt_spo_pkg::t_in_item             i_in_data,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output mppt_spo_pkg::t_out_item            o_out_data,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mppt_spo_pkg::ADDR_W-1:0]    paddr,
    input  logic [mppt_spo_pkg::DATA_W-1:0]    pwdata,
    output logic [mppt_spo_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);
    import mppt_spo_pkg::*;

    // configuration registers
    logic [POWER_W-1:0] r_power_floor;
    logic [REG_W-1:0]   r_sweep_start;
    logic [REG_W-1:0]   r_sweep_step;
    logic [REG_W-1:0]   r_sweep_end;
    logic [REG_W-1:0]   r_track_step;
    logic [REG_W-1:0]   r_duty_min;
    logic [REG_W-1:0]   r_duty_max;

    // tracker state
    logic               r_tracking;
    logic [REG_W-1:0]   r_duty;
    logic [REG_W-1:0]   r_best_duty;
    logic [POWER_W-1:0] r_best_power;
    logic [POWER_W-1:0] r_prev_power;
    logic               r_moving_down;

    // pipeline
    logic               r_in_valid;
    t_in_item           r_in_data;
    logic               r_out_valid;
    t_out_item          r_out_data;

    // step logic
    logic               advance;
    logic               step_en;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;
    logic [REG_W-1:0]   wdata14;
    logic [PROD_W-1:0]  prod;
    logic [POWER_W-1:0] raw_power;
    logic [POWER_W-1:0] trk_power;
    logic [REG_W-1:0]   eff_step;
    logic               sweep_point;
    logic [REG_W:0]     sweep_next;
    logic               sweep_done;
    logic               best_upd;
    logic [REG_W-1:0]   best_duty_new;
    logic               down_new;
    logic signed [REG_W+1:0] trk_sum;
    logic signed [REG_W+1:0] trk_hi;
    logic signed [REG_W+1:0] trk_lo;
    logic [REG_W-1:0]   trk_duty;

    logic               n_tracking;
    logic [REG_W-1:0]   n_duty;
    logic [REG_W-1:0]   n_best_duty;
    logic [POWER_W-1:0] n_best_power;
    logic [POWER_W-1:0] n_prev_power;
    logic               n_moving_down;
    t_out_item          n_out_data;

    // ---------------------------------------------------------------------
    // Handshake: the result register frees when empty or taken; the input
    // register frees when empty or when its item moves to the result side.
    // ---------------------------------------------------------------------
    assign advance     = !r_out_valid || i_out_ready;
    assign step_en     = r_in_valid && advance;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ---------------------------------------------------------------------
    // APB decode: always ready, write lands on the access cycle.
    // ---------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wdata14 = pwdata[REG_W-1:0];

    always_comb begin
        case (cfg_idx)
            REG_POWER_FLOOR: prdata = DATA_W'(r_power_floor);
            REG_SWEEP_START: prdata = DATA_W'(r_sweep_start);
            REG_SWEEP_STEP:  prdata = DATA_W'(r_sweep_step);
            REG_SWEEP_END:   prdata = DATA_W'(r_sweep_end);
            REG_TRACK_STEP:  prdata = DATA_W'(r_track_step);
            REG_DUTY_MIN:    prdata = DATA_W'(r_duty_min);
            REG_DUTY_MAX:    prdata = DATA_W'(r_duty_max);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Per-sample step, from the input register and the tracker state.
    // ---------------------------------------------------------------------
    // Raw power, saturated to the power field (cannot trip at 10-bit codes).
    assign prod      = PROD_W'(r_in_data.voltage_code) * PROD_W'(r_in_data.current_code);
    assign raw_power = (PROD_W'(prod) > PROD_W'(POWER_MAX)) ? POWER_MAX
                                                            : POWER_W'(prod);

    // Sweep: a zero step behaves as one so the sweep always finishes.
    assign eff_step      = (r_sweep_step == '0) ? REG_W'(1) : r_sweep_step;
    assign sweep_point   = r_duty < r_sweep_end;
    assign sweep_next    = {1'b0, r_duty} + {1'b0, eff_step};
    assign sweep_done    = !sweep_point || (sweep_next >= {1'b0, r_sweep_end});
    assign best_upd      = sweep_point && (raw_power > r_best_power);
    assign best_duty_new = best_upd ? r_duty : r_best_duty;

    // Tracking: floor the power, flip direction unless power rose, then
    // step and clamp (upper limit first, so crossed limits give duty_min).
    assign trk_power = (raw_power < r_power_floor) ? '0 : raw_power;
    assign down_new  = (trk_power > r_prev_power) ? r_moving_down : !r_moving_down;
    assign trk_sum   = down_new
                     ? $signed({2'b00, r_duty}) - $signed({2'b00, r_track_step})
                     : $signed({2'b00, r_duty}) + $signed({2'b00, r_track_step});
    assign trk_hi    = (trk_sum > $signed({2'b00, r_duty_max}))
                     ? $signed({2'b00, r_duty_max}) : trk_sum;
    assign trk_lo    = (trk_hi < $signed({2'b00, r_duty_min}))
                     ? $signed({2'b00, r_duty_min}) : trk_hi;
    assign trk_duty  = trk_lo[REG_W-1:0];

    always_comb begin
        n_tracking    = r_tracking;
        n_duty        = r_duty;
        n_best_duty   = r_best_duty;
        n_best_power  = r_best_power;
        n_prev_power  = r_prev_power;
        n_moving_down = r_moving_down;
        n_out_data    = '0;
        if (!r_tracking) begin
            if (best_upd) begin
                n_best_power = raw_power;
            end
            n_best_duty = best_duty_new;
            if (sweep_done) begin
                // hand over to tracking at the best duty, heading upward
                n_tracking    = 1'b1;
                n_moving_down = 1'b0;
                n_duty        = best_duty_new;
            end else begin
                n_duty = sweep_next[REG_W-1:0];
            end
            n_out_data.power = raw_power;
        end else begin
            n_moving_down    = down_new;
            n_duty           = trk_duty;
            n_prev_power     = trk_power;
            n_out_data.power = trk_power;
        end
        n_out_data.duty     = DUTY_BITS'(n_duty);
        n_out_data.tracking = n_tracking;
    end

    // ---------------------------------------------------------------------
    // Configuration registers. A sweep start write during the sweep restarts
    // it; the user must keep items out of flight during writes (unenforced).
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_floor <= RST_POWER_FLOOR;
            r_sweep_start <= RST_SWEEP_START;
            r_sweep_step  <= RST_SWEEP_STEP;
            r_sweep_end   <= RST_SWEEP_END;
            r_track_step  <= RST_TRACK_STEP;
            r_duty_min    <= RST_DUTY_MIN;
            r_duty_max    <= RST_DUTY_MAX;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_POWER_FLOOR: r_power_floor <= pwdata[POWER_W-1:0];
                REG_SWEEP_START: r_sweep_start <= wdata14;
                REG_SWEEP_STEP:  r_sweep_step  <= wdata14;
                REG_SWEEP_END:   r_sweep_end   <= wdata14;
                REG_TRACK_STEP:  r_track_step  <= wdata14;
                REG_DUTY_MIN:    r_duty_min    <= wdata14;
                REG_DUTY_MAX:    r_duty_max    <= wdata14;
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Tracker state: advance on each item, else take a sweep restart.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking    <= 1'b0;
            r_duty        <= RST_SWEEP_START;
            r_best_duty   <= '0;
            r_best_power  <= '0;
            r_prev_power  <= '0;
            r_moving_down <= 1'b0;
        end else if (step_en) begin
            r_tracking    <= n_tracking;
            r_duty        <= n_duty;
            r_best_duty   <= n_best_duty;
            r_best_power  <= n_best_power;
            r_prev_power  <= n_prev_power;
            r_moving_down <= n_moving_down;
        end else if (cfg_wr && cfg_idx == REG_SWEEP_START && !r_tracking) begin
            r_duty       <= wdata14;
            r_best_duty  <= '0;
            r_best_power <= '0;
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline valids (control) and payload (no reset needed).
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
        if (step_en) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ===== hw/rtl/mppt_spo_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPPT tracker port checker
// Watches the top-level ports over time; bound to the tracker below.
// ----------------------------------------------------------------------------
module mppt_spo_chk (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_ready,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  mppt_spo_pkg::t_out_item  i_out_data,
    input  logic                     i_pready
);
    import mppt_spo_pkg::*;

    logic r_seen_tracking;

    // remember that a tracking result has gone out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_tracking <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_out_data.tracking) begin
            r_seen_tracking <= 1'b1;
        end
    end

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready dropped");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_tracking_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_tracking && i_out_valid |-> i_out_data.tracking)
        else $error("phase went back to sweep without reset");

endmodule

bind mppt_sweep_then_perturb_observe mppt_spo_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data),
    .i_pready    (pready)
);

// ===== tb/mppt_sweep_then_perturb_observe_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPPT sweep / P&O tracker testbench
// Drives voltage/current sample transfers and APB register writes into the
// tracker, predicts every result with a cycle-free model of the sweep and the
// perturb-and-observe steps, and checks each result transfer field by field
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module mppt_sweep_then_perturb_observe_test;
    import mppt_spo_pkg::*;

    // Address 28 decodes to no register; writes there must change nothing.
    localparam int unsigned REG_UNUSED   = 7;
    localparam int unsigned RANDOM_ITEMS = 850;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam logic [REG_W-1:0] REG14_MAX = {REG_W{1'b1}};

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the tracker state and holds the duty results that
    // are still to come out of the block, oldest first.
    // ------------------------------------------------------------------------
    class duty_scoreboard;
        logic [POWER_W-1:0]   power_floor;
        logic [REG_W-1:0]     sweep_start, sweep_step, sweep_end;
        logic [REG_W-1:0]     track_step, duty_min, duty_max;

        bit                   tracking;
        logic [DUTY_BITS-1:0] duty;
        logic [DUTY_BITS-1:0] best_duty;
        logic [POWER_W-1:0]   best_power;
        logic [POWER_W-1:0]   last_power;
        bit                   moving_down;

        t_out_item            pending_results[$];
        int unsigned          checked;
        int unsigned          failures;

        function new();
            power_floor = RST_POWER_FLOOR;
            sweep_start = RST_SWEEP_START;
            sweep_step  = RST_SWEEP_STEP;
            sweep_end   = RST_SWEEP_END;
            track_step  = RST_TRACK_STEP;
            duty_min    = RST_DUTY_MIN;
            duty_max    = RST_DUTY_MAX;
            tracking    = 1'b0;
            duty        = RST_SWEEP_START;
            best_duty   = '0;
            best_power  = '0;
            last_power  = '0;
            moving_down = 1'b0;
            checked     = 0;
            failures    = 0;
        endfunction

        function void write_reg(int unsigned idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_POWER_FLOOR: power_floor = val[POWER_W-1:0];
                REG_SWEEP_START: begin
                    sweep_start = val[REG_W-1:0];
                    // restart the sweep only while it is still running
                    if (!tracking) begin
                        duty       = val[REG_W-1:0];
                        best_duty  = '0;
                        best_power = '0;
                    end
                end
                REG_SWEEP_STEP:  sweep_step = val[REG_W-1:0];
                REG_SWEEP_END:   sweep_end  = val[REG_W-1:0];
                REG_TRACK_STEP:  track_step = val[REG_W-1:0];
                REG_DUTY_MIN:    duty_min   = val[REG_W-1:0];
                REG_DUTY_MAX:    duty_max   = val[REG_W-1:0];
                default: ;
            endcase
        endfunction

        // Samples left until the sweep hands over to tracking (the last one
        // included); zero once tracking.
        function int unsigned sweep_left();
            int unsigned stride;
            stride = (sweep_step == 0) ? 1 : sweep_step;
            if (tracking)
                return 0;
            if (duty >= sweep_end)
                return 1;
            return (sweep_end - duty + stride - 1) / stride;
        endfunction

        // Advance the tracker by one accepted sample and queue its result.
        function void note_sample(t_in_item s);
            int unsigned        prod, stride, next_duty;
            int                 d;
            bit                 on_point;
            logic [POWER_W-1:0] p;
            t_out_item          r;
            prod = s.voltage_code * s.current_code;
            p    = (prod > POWER_MAX) ? POWER_MAX : prod[POWER_W-1:0];
            if (!tracking) begin
                stride    = (sweep_step == 0) ? 1 : sweep_step;
                on_point  = duty < sweep_end;
                next_duty = duty + stride;
                if (on_point && p > best_power) begin
                    best_power = p;
                    best_duty  = duty;
                end
                if (!on_point || next_duty >= sweep_end) begin
                    tracking    = 1'b1;
                    moving_down = 1'b0;
                    duty        = best_duty;
                end else begin
                    duty = next_duty[DUTY_BITS-1:0];
                end
            end else begin
                if (p < power_floor)
                    p = '0;
                if (!(p > last_power))
                    moving_down = !moving_down;
                d = int'(duty);
                d = moving_down ? d - int'(track_step) : d + int'(track_step);
                if (d > int'(duty_max))
                    d = int'(duty_max);
                if (d < int'(duty_min))
                    d = int'(duty_min);
                duty       = d[DUTY_BITS-1:0];
                last_power = p;
            end
            r.duty     = duty;
            r.tracking = tracking;
            r.power    = p;
            pending_results.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            checked++;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: duty=%0d tracking=%0d power=%0d",
                             got.duty, got.tracking, got.power);
                return;
            end
            want = pending_results.pop_front();
            if (got.duty !== want.duty || got.tracking !== want.tracking ||
                got.power !== want.power) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("result %0d: expected duty=%0d tracking=%0d power=%0d,",
                             checked, want.duty, want.tracking, want.power,
                             " got duty=%0d tracking=%0d power=%0d",
                             got.duty, got.tracking, got.power);
            end
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals: every input of the block starts at a known value.
    // ------------------------------------------------------------------------
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    t_in_item          in_data   = '0;
    logic              out_ready = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic              in_ready;
    logic              out_valid;
    t_out_item         out_data;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    duty_scoreboard    sb;
    bit                calm = 1'b0;     // phase runs with no idling at all
    logic [9:0]        walk_v = 10'd500;
    logic [9:0]        walk_c = 10'd500;
    int unsigned       samples_sent = 0;
    int unsigned       random_sent  = 0;
    int unsigned       reg_writes   = 0;

    mppt_sweep_then_perturb_observe u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #5_000_000;
        $display("timeout with %0d results still pending", sb.pending());
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. Check the result
    // first; a result can never belong to the sample accepted at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid === 1'b1 && out_ready)
                sb.check_result(out_data);
            if (in_valid && in_ready === 1'b1)
                sb.note_sample(in_data);
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic t_in_item sample_of(int unsigned v, int unsigned c);
        t_in_item s;
        s.voltage_code = v[ADC_BITS-1:0];
        s.current_code = c[ADC_BITS-1:0];
        return s;
    endfunction

    // Random walk over the codes so power rises and falls in runs, with
    // occasional jumps and corner codes to keep every bit moving.
    function automatic t_in_item next_walk();
        int unsigned r;
        int          v, c;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            walk_v = 10'($urandom_range(0, 1023));
            walk_c = 10'($urandom_range(0, 1023));
        end else if (r < 16) begin
            walk_v = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            walk_c = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        end else begin
            v = int'(walk_v) + int'($urandom_range(0, 24)) - 12;
            c = int'(walk_c) + int'($urandom_range(0, 24)) - 12;
            walk_v = (v < 0) ? 10'd0 : (v > 1023) ? 10'd1023 : v[9:0];
            walk_c = (c < 0) ? 10'd0 : (c > 1023) ? 10'd1023 : c[9:0];
        end
        return sample_of(walk_v, walk_c);
    endfunction

    // Present one sample and hold it until the transfer. With no gap, valid
    // stays high and only the payload advances.
    task automatic send_sample(t_in_item s);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = s;
        do @(posedge clk); while (in_ready !== 1'b1);
        samples_sent++;
    endtask

    task automatic send_walk(int unsigned n);
        repeat (n) send_sample(next_walk());
        random_sent += n;
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(int unsigned idx, logic [DATA_W-1:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(idx * 4);
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        sb.write_reg(idx, val);
        reg_writes++;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drop valid, wait until every expected result came out, then let the
    // two pipeline stages run empty before touching a register.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Result side: bursts of ready broken by random stalls.
    initial begin
        int unsigned stall;
        @(negedge clk);
        forever begin
            out_ready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
            stall = pick_gap();
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. The sweep only runs once after reset unless sweep_start is
    // rewritten while it is still running, so sweep coverage comes first:
    // directed points, several restarts with odd settings, then one sweep
    // that is allowed to finish. Everything after that is tracking.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned left, n, r, ending, restarts, track_phases;
        logic [REG_W-1:0] lo, hi;
        string ending_name;

        sb           = new();
        restarts     = 0;
        track_phases = 0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Sweep at reset settings: corner codes, including full scale on
        // both channels so the best point is well defined.
        send_sample(sample_of(0, 0));
        send_sample(sample_of(1023, 1023));
        send_sample(sample_of(1023, 0));
        send_sample(sample_of(0, 1023));
        send_sample(sample_of(1, 1));
        send_sample(sample_of(700, 700));
        settle();

        // Restart near the top of the duty range with a zero step, which
        // must behave as a step of one.
        apb_write(REG_SWEEP_STEP, 0);
        apb_write(REG_SWEEP_END, REG14_MAX);
        apb_write(REG_SWEEP_START, 16380);
        restarts++;
        send_sample(sample_of(1, 2));
        send_sample(sample_of(3, 4));
        settle();

        // Random restarts; stop at least one sample short of the end of each sweep.
        repeat (4) begin
            calm = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 9);
            apb_write(REG_SWEEP_STEP,
                      (r == 0) ? 0 : (r == 1) ? REG14_MAX : $urandom_range(1, 400));
            lo = ($urandom_range(0, 3) == 0) ? '0 : REG_W'($urandom_range(0, 15000));
            hi = ($urandom_range(0, 3) == 0) ? REG14_MAX
                                             : REG_W'(lo + $urandom_range(0, 1383));
            apb_write(REG_SWEEP_END, hi);
            apb_write(REG_SWEEP_START, lo);
            restarts++;
            left = sb.sweep_left();
            n    = $urandom_range(3, 30);
            send_walk((n < left - 1) ? n : left - 1);
            settle();
        end

        // The one sweep that runs to completion: a normal finish, a sweep
        // that never sees power above zero, or a sweep with no points at all.
        calm   = 1'b0;
        ending = $urandom_range(0, 2);
        if (ending == 2) begin
            ending_name = "an empty sweep";
            hi = REG_W'($urandom_range(0, 16000));
            apb_write(REG_SWEEP_END, hi);
            apb_write(REG_SWEEP_START, hi + $urandom_range(0, 383));
            restarts++;
            send_walk(1);
        end else begin
            lo = REG_W'($urandom_range(0, 8000));
            n  = $urandom_range(1, 300);
            apb_write(REG_SWEEP_STEP, n);
            apb_write(REG_SWEEP_END, lo + n * $urandom_range(5, 25));
            apb_write(REG_SWEEP_START, lo);
            restarts++;
            left = sb.sweep_left();
            if (ending == 0) begin
                ending_name = "a normal finish";
                send_walk(left);
            end else begin
                ending_name = "a sweep with no power";
                repeat (left) begin
                    if ($urandom_range(0, 1))
                        send_sample(sample_of($urandom_range(0, 1023), 0));
                    else
                        send_sample(sample_of(0, $urandom_range(0, 1023)));
                end
                random_sent += left;
            end
        end
        settle();

        // Tracking at reset limits: zero power, rising, equal, falling, and
        // a sample below the floor, then full scale.
        apb_write(REG_POWER_FLOOR, RST_POWER_FLOOR);
        apb_write(REG_TRACK_STEP, RST_TRACK_STEP);
        apb_write(REG_DUTY_MIN, RST_DUTY_MIN);
        apb_write(REG_DUTY_MAX, RST_DUTY_MAX);
        send_sample(sample_of(0, 0));
        send_sample(sample_of(100, 100));
        send_sample(sample_of(100, 100));
        send_sample(sample_of(50, 50));
        send_sample(sample_of(40, 40));
        send_sample(sample_of(1023, 1023));
        settle();

        // Full-range step hits both clamps; sweep_start and the unused
        // address must both be ignored now.
        apb_write(REG_TRACK_STEP, REG14_MAX);
        apb_write(REG_DUTY_MIN, 0);
        apb_write(REG_DUTY_MAX, REG14_MAX);
        apb_write(REG_SWEEP_START, 1234);
        apb_write(REG_UNUSED, 32'h0000_3FFF);
        send_sample(sample_of(10, 10));
        send_sample(sample_of(20, 20));
        send_sample(sample_of(30, 30));
        send_sample(sample_of(5, 5));
        settle();

        // Crossed limits: the lower clamp wins.
        apb_write(REG_DUTY_MIN, 9000);
        apb_write(REG_DUTY_MAX, 100);
        send_sample(sample_of(1023, 1023));
        send_sample(sample_of(0, 0));
        send_sample(sample_of(500, 500));
        settle();

        // Zero step: direction still flips, duty only clamps.
        apb_write(REG_TRACK_STEP, 0);
        apb_write(REG_DUTY_MIN, 0);
        apb_write(REG_DUTY_MAX, REG14_MAX);
        send_sample(sample_of(30, 30));
        send_sample(sample_of(30, 30));
        send_sample(sample_of(60, 60));
        settle();

        // Floor at full scale: every sample counts as zero.
        apb_write(REG_POWER_FLOOR, POWER_MAX);
        send_sample(sample_of(1023, 1023));
        send_sample(sample_of(1023, 1023));
        settle();

        // Random tracking phases with a fresh mix of settings each time.
        while (random_sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1)) begin
                r = $urandom_range(0, 9);
                apb_write(REG_POWER_FLOOR, (r == 0) ? 0 : (r == 1) ? POWER_MAX
                                                    : $urandom_range(0, 150000));
            end
            if ($urandom_range(0, 1)) begin
                r = $urandom_range(0, 9);
                apb_write(REG_TRACK_STEP, (r == 0) ? 0 : (r == 1) ? REG14_MAX
                                                   : $urandom_range(1, 400));
            end
            if ($urandom_range(0, 4) < 3) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    lo = '0;
                    hi = REG14_MAX;
                end else if (r == 1) begin
                    lo = REG_W'($urandom_range(8000, 16383));
                    hi = REG_W'($urandom_range(0, 7999));
                end else begin
                    lo = REG_W'($urandom_range(0, 8000));
                    hi = REG_W'(lo + $urandom_range(0, 8383));
                end
                apb_write(REG_DUTY_MIN, lo);
                apb_write(REG_DUTY_MAX, hi);
            end
            if ($urandom_range(0, 7) == 0)
                apb_write(REG_SWEEP_START, $urandom_range(0, 16383));
            if ($urandom_range(0, 7) == 0)
                apb_write(REG_SWEEP_STEP, $urandom_range(0, 16383));
            if ($urandom_range(0, 7) == 0)
                apb_write(REG_SWEEP_END, $urandom_range(0, 16383));
            if ($urandom_range(0, 7) == 0)
                apb_write(REG_UNUSED, $urandom_range(0, 16383));
            send_walk($urandom_range(20, 80));
            track_phases++;
            settle();
        end

        $display("Sent %0d samples (%0d random), checked %0d results, %0d register writes.",
                 samples_sent, random_sent, sb.checked, reg_writes);
        $display("Sweep restarted %0d times and ended with %s; %0d random tracking phases.",
                 restarts, ending_name, track_phases);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.failures, sb.pending());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mppt_spo_pkg.sv
hw/rtl/mppt_sweep_then_perturb_observe.sv
hw/rtl/mppt_spo_chk.sv
tb/mppt_sweep_then_perturb_observe_test.sv
